// File: hw/rtl/fwlt_pkg.sv
// ----------------------------------------------------------------------------
// fwlt_pkg
// Shared types, codes and constants of the flow window loss tracker.
// ----------------------------------------------------------------------------
package fwlt_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = 8;
  localparam int CNT_W         = 20;
  localparam int MISS_W        = 21;
  localparam int WIN_W         = 8;
  localparam int RX_SEQ_W      = 32;
  localparam int SEQ_BITS_DEF  = 20;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 20;

  localparam logic [CNT_W-1:0]  CNT_MAX              = 20'hFFFFF;
  localparam logic [MISS_W-1:0] MISSING_MAX          = 21'd2000000;
  localparam logic [CNT_W-1:0]  TIMEOUT_RESET        = 20'd65535;
  localparam logic [CNT_W-1:0]  TIMEOUT_DOUBLE_BELOW = 20'd500000;
  localparam logic [CNT_W-1:0]  TIMEOUT_CEIL         = 20'd999999;
  localparam logic [CNT_W-1:0]  TIMEOUT_FLOOR        = 20'd15;
  localparam logic [IDX_W-1:0]  IDX_LAST             = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FITS  = 2'd2;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_RECV    = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_FINISH  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_SENT    = 3'd0,
    KIND_ACCEPT  = 3'd1,
    KIND_DISCARD = 3'd2,
    KIND_TIMEOUT = 3'd3,
    KIND_FINISH  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_CHK,
    ST_S_WR,
    ST_S_OUT0,
    ST_S_OUT1,
    ST_S_OUTL,
    ST_R_CHK,
    ST_T_SCAN,
    ST_T_RD,
    ST_F_SCAN,
    ST_F_END,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [RX_SEQ_W-1:0] rx_seqno;
    logic [IDX_W-1:0]    rx_tag;
    logic                rx_full;
  } cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic [CNT_W-1:0]   seqno;
    logic               missed_flag;
    logic [CNT_W-1:0]   missed_seqno;
    logic [CNT_W-1:0]   timeout_us;
    logic [WIN_W-1:0]   window_now;
    logic [CNT_W-1:0]   sent_total;
    logic [CNT_W-1:0]   received_total;
    logic [MISS_W-1:0]  missing_total;
    logic               finished;
    logic               last;
  } result_t;

endpackage

// File: hw/rtl/fwlt_front.sv
// ----------------------------------------------------------------------------
// fwlt_front
// Input side: takes event transfers, decodes the operation and queues them.
// ----------------------------------------------------------------------------
module fwlt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [fwlt_pkg::RX_SEQ_W-1:0] in_seqno,
  input  logic [fwlt_pkg::IDX_W-1:0]    in_tag,
  input  logic                          in_full,
  output logic                          cmd_valid,
  output fwlt_pkg::cmd_t                cmd,
  input  logic                          cmd_pop
);
  import fwlt_pkg::*;

  cmd_t       ent [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       in_cmd;

  always_comb begin
    in_cmd.op       = op_t'(in_op);
    in_cmd.rx_seqno = in_seqno;
    in_cmd.rx_tag   = in_tag;
    in_cmd.rx_full  = in_full;
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = ent[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: hw/rtl/fwlt_back.sv
// ----------------------------------------------------------------------------
// fwlt_back
// Event engine: sequence table, counters, window and timeout control, and
// the result register.
// ----------------------------------------------------------------------------
module fwlt_back #(
  parameter int SEQ_BITS = fwlt_pkg::SEQ_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  fwlt_pkg::cmd_t                  cmd,
  output logic                            cmd_pop,
  input  logic                            cfg_we,
  input  logic [fwlt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fwlt_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            res_valid,
  output fwlt_pkg::result_t               res,
  input  logic                            res_ready
);
  import fwlt_pkg::*;

  function automatic logic run_over(input logic run, input logic [CNT_W-1:0] rc,
                                    input logic [MISS_W-1:0] mc,
                                    input logic [CNT_W-1:0] pc);
    logic [MISS_W:0] sum;
    sum = (MISS_W+1)'(rc) + (MISS_W+1)'(mc);
    return !run || (sum >= (MISS_W+1)'(pc));
  endfunction

  state_t state, state_next;

  logic [CNT_W-1:0]         sent, sent_next;
  logic [CNT_W-1:0]         recv, recv_next;
  logic [MISS_W-1:0]        missing, missing_next;
  logic [WIN_W-1:0]         window, window_next;
  logic [1:0]               burst, burst_next;
  logic [CNT_W-1:0]         timeout, timeout_next;
  logic                     running, running_next;
  logic [TABLE_ENTRIES-1:0] valid, valid_next;
  logic [CNT_W-1:0]         pc, pc_next;
  logic [WIN_W-1:0]         wl, wl_next;
  logic                     hf, hf_next;

  cmd_t                     cmd_r, cmd_r_next;
  kind_t                    kind_r, kind_next;
  logic                     mflag, mflag_next;
  logic [CNT_W-1:0]         mseq, mseq_next;
  logic                     cap, cap_next;
  logic [IDX_W-1:0]         cnt, cnt_next;
  logic                     k, k_next;
  logic [CNT_W-1:0]         p0_seq, p0_seq_next;
  logic                     p0_mfl, p0_mfl_next;
  logic [CNT_W-1:0]         p0_mseq, p0_mseq_next;
  logic [CNT_W-1:0]         p1_seq, p1_seq_next;
  logic                     p1_mfl, p1_mfl_next;
  logic [CNT_W-1:0]         p1_mseq, p1_mseq_next;

  logic                     out_valid, out_valid_next;
  result_t                  out_res, out_res_next;

  logic [SEQ_BITS-1:0]      mem [TABLE_ENTRIES];
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [SEQ_BITS-1:0]      mem_wdata;
  logic [IDX_W-1:0]         mem_raddr;
  logic [SEQ_BITS-1:0]      mem_rdata;

  logic                     load_ok;
  logic                     over;
  logic [CNT_W-1:0]         sent_p1;
  logic [IDX_W-1:0]         sidx;
  logic [MISS_W:0]          credit;
  logic                     hit;
  logic                     ok;
  logic [MISS_W-1:0]        miss_show;
  logic [MISS_W-1:0]        miss_inc;
  result_t                  base;

  assign res_valid = out_valid;
  assign res       = out_res;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_comb begin
    load_ok  = !out_valid || res_ready;
    over     = run_over(running, recv, missing, pc);
    sent_p1  = sent + 1'b1;
    sidx     = sent_p1[IDX_W-1:0];
    credit   = (MISS_W+1)'(recv) + (MISS_W+1)'(missing) + (MISS_W+1)'(window);
    miss_inc = (missing < MISSING_MAX) ? missing + 1'b1 : missing;
    hit      = hf && valid[sidx];
    ok       = valid[cmd_r.rx_tag] &&
               (!cmd_r.rx_full || (RX_SEQ_W'(mem_rdata) == cmd_r.rx_seqno));
    miss_show = p1_mfl ? missing - 1'b1 : missing;

    base.kind           = kind_r;
    base.seqno          = '0;
    base.missed_flag    = mflag;
    base.missed_seqno   = mflag ? mseq : '0;
    base.timeout_us     = timeout;
    base.window_now     = window;
    base.sent_total     = sent;
    base.received_total = recv;
    base.missing_total  = missing;
    base.finished       = over;
    base.last           = 1'b1;

    state_next     = state;
    sent_next      = sent;
    recv_next      = recv;
    missing_next   = missing;
    window_next    = window;
    burst_next     = burst;
    timeout_next   = timeout;
    running_next   = running;
    valid_next     = valid;
    pc_next        = pc;
    wl_next        = wl;
    hf_next        = hf;
    cmd_r_next     = cmd_r;
    kind_next      = kind_r;
    mflag_next     = mflag;
    mseq_next      = mseq;
    cap_next       = 1'b0;
    cnt_next       = cnt;
    k_next         = k;
    p0_seq_next    = p0_seq;
    p0_mfl_next    = p0_mfl;
    p0_mseq_next   = p0_mseq;
    p1_seq_next    = p1_seq;
    p1_mfl_next    = p1_mfl;
    p1_mseq_next   = p1_mseq;
    out_valid_next = out_valid && !res_ready;
    out_res_next   = out_res;
    cmd_pop        = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = sidx;
    mem_wdata      = SEQ_BITS'(sent_p1);
    mem_raddr      = '0;

    if (cap) begin
      mseq_next = mem_rdata[CNT_W-1:0];
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_PACKET_COUNT: pc_next = cfg_data[CNT_W-1:0];
        CFG_WINDOW_LIMIT: wl_next = cfg_data[WIN_W-1:0];
        CFG_HEADER_FITS:  hf_next = cfg_data[0];
        default: ;
      endcase
    end

    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          cmd_r_next = cmd;
          mflag_next = 1'b0;
          mseq_next  = '0;
          k_next     = 1'b0;
          cnt_next   = '0;
          case (cmd.op)
            OP_SEND: begin
              if (!over) begin
                state_next = ST_S_CHK;
              end
            end
            OP_RECV: begin
              kind_next = KIND_DISCARD;
              if (over) begin
                state_next = ST_EMIT;
              end else begin
                mem_raddr  = cmd.rx_tag;
                state_next = ST_R_CHK;
              end
            end
            OP_TIMEOUT: begin
              kind_next = KIND_TIMEOUT;
              if (over) begin
                state_next = ST_EMIT;
              end else begin
                if (burst == 2'd1) begin
                  window_next = '0;
                end
                burst_next = 2'd1;
                if (timeout < TIMEOUT_DOUBLE_BELOW) begin
                  timeout_next = {timeout[CNT_W-2:0], 1'b0};
                  state_next   = ST_EMIT;
                end else begin
                  cnt_next   = sidx;
                  state_next = ST_T_SCAN;
                end
              end
            end
            OP_FINISH: begin
              kind_next  = KIND_FINISH;
              state_next = ST_F_SCAN;
            end
            default: ;
          endcase
        end
      end

      ST_S_CHK: begin
        if (({1'b0, k} < burst) && ((MISS_W+1)'(sent) <= credit) &&
            (sent < pc) && (sent < CNT_MAX)) begin
          mem_raddr  = sidx;
          state_next = ST_S_WR;
        end else if (k) begin
          state_next = ST_S_OUTL;
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_S_WR: begin
        sent_next = sent_p1;
        if (hit) begin
          missing_next = miss_inc;
        end
        if (hf) begin
          valid_next[sidx] = 1'b1;
          mem_we           = 1'b1;
        end
        if (!k) begin
          p0_seq_next  = sent_p1;
          p0_mfl_next  = hit;
          p0_mseq_next = hit ? mem_rdata[CNT_W-1:0] : '0;
          k_next       = 1'b1;
          state_next   = ST_S_CHK;
        end else begin
          p1_seq_next  = sent_p1;
          p1_mfl_next  = hit;
          p1_mseq_next = hit ? mem_rdata[CNT_W-1:0] : '0;
          state_next   = ST_S_OUT0;
        end
      end

      ST_S_OUT0: begin
        if (load_ok) begin
          out_valid_next            = 1'b1;
          out_res_next              = base;
          out_res_next.kind         = KIND_SENT;
          out_res_next.seqno        = p0_seq;
          out_res_next.missed_flag  = p0_mfl;
          out_res_next.missed_seqno = p0_mseq;
          out_res_next.sent_total   = p0_seq;
          out_res_next.missing_total = miss_show;
          out_res_next.finished     = run_over(running, recv, miss_show, pc);
          out_res_next.last         = 1'b0;
          state_next                = ST_S_OUT1;
        end
      end

      ST_S_OUT1: begin
        if (load_ok) begin
          out_valid_next            = 1'b1;
          out_res_next              = base;
          out_res_next.kind         = KIND_SENT;
          out_res_next.seqno        = p1_seq;
          out_res_next.missed_flag  = p1_mfl;
          out_res_next.missed_seqno = p1_mseq;
          state_next                = ST_IDLE;
        end
      end

      ST_S_OUTL: begin
        if (load_ok) begin
          out_valid_next            = 1'b1;
          out_res_next              = base;
          out_res_next.kind         = KIND_SENT;
          out_res_next.seqno        = p0_seq;
          out_res_next.missed_flag  = p0_mfl;
          out_res_next.missed_seqno = p0_mseq;
          state_next                = ST_IDLE;
        end
      end

      ST_R_CHK: begin
        state_next = ST_EMIT;
        if (!ok) begin
          burst_next = 2'd0;
          kind_next  = KIND_DISCARD;
        end else begin
          kind_next = KIND_ACCEPT;
          if (cmd_r.rx_full && (cmd_r.rx_seqno == RX_SEQ_W'(pc))) begin
            running_next = 1'b0;
          end
          valid_next[cmd_r.rx_tag] = 1'b0;
          if (recv < CNT_MAX) begin
            recv_next = recv + 1'b1;
          end
          if ((burst == 2'd2) && (timeout > TIMEOUT_FLOOR)) begin
            timeout_next = timeout - (timeout >> 4);
          end
          burst_next = 2'd2;
          if (window < wl) begin
            window_next = window + 1'b1;
          end
        end
      end

      ST_T_SCAN: begin
        if (valid[cnt]) begin
          mem_raddr       = cnt;
          valid_next[cnt] = 1'b0;
          missing_next    = miss_inc;
          state_next      = ST_T_RD;
        end else if (cnt == sent[IDX_W-1:0]) begin
          timeout_next = TIMEOUT_CEIL;
          state_next   = ST_EMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_T_RD: begin
        mflag_next   = 1'b1;
        mseq_next    = mem_rdata[CNT_W-1:0];
        timeout_next = TIMEOUT_CEIL;
        state_next   = ST_EMIT;
      end

      ST_F_SCAN: begin
        if (valid[cnt]) begin
          valid_next[cnt] = 1'b0;
          missing_next    = miss_inc;
          if (!mflag) begin
            mflag_next = 1'b1;
            mem_raddr  = cnt;
            cap_next   = 1'b1;
          end
        end
        if (cnt == IDX_LAST) begin
          state_next = ST_F_END;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_F_END: begin
        running_next = 1'b0;
        state_next   = ST_EMIT;
      end

      ST_EMIT: begin
        if (load_ok) begin
          out_valid_next = 1'b1;
          out_res_next   = base;
          state_next     = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sent      <= '0;
      recv      <= '0;
      missing   <= '0;
      window    <= '0;
      burst     <= 2'd1;
      timeout   <= TIMEOUT_RESET;
      running   <= 1'b1;
      valid     <= '0;
      pc        <= CNT_W'(1);
      wl        <= '0;
      hf        <= 1'b1;
      cap       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sent      <= sent_next;
      recv      <= recv_next;
      missing   <= missing_next;
      window    <= window_next;
      burst     <= burst_next;
      timeout   <= timeout_next;
      running   <= running_next;
      valid     <= valid_next;
      pc        <= pc_next;
      wl        <= wl_next;
      hf        <= hf_next;
      cap       <= cap_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_r_next;
    kind_r  <= kind_next;
    mflag   <= mflag_next;
    mseq    <= mseq_next;
    cnt     <= cnt_next;
    k       <= k_next;
    p0_seq  <= p0_seq_next;
    p0_mfl  <= p0_mfl_next;
    p0_mseq <= p0_mseq_next;
    p1_seq  <= p1_seq_next;
    p1_mfl  <= p1_mfl_next;
    p1_mseq <= p1_mseq_next;
    out_res <= out_res_next;
  end

endmodule

// File: hw/rtl/flow_window_loss_tracker.sv
// ----------------------------------------------------------------------------
// flow_window_loss_tracker
// Sender side of an echo flow test: issues sequence numbers under a window,
// matches echoes against a 256-entry table, and tracks loss and timeout.
// ----------------------------------------------------------------------------
// Events are queued two deep and executed one at a time by a state machine
// whose table reads go through a single registered memory port. A receive
// checks its tag against the table and then loads its result; a timeout that
// only doubles goes straight to its result. A send burst makes a check and a
// table step for each number sent, loads one result per number, and makes one
// more check when the burst stops short of two; a timeout that gives up on an
// entry walks the table one index a cycle; a finish walks all 256 entries.
// The result register lets the next event start while a result waits on
// m_tready. No clearing pass is needed after reset: table entries carry
// valid flags.
module flow_window_loss_tracker #(
  parameter int SEQ_BITS = fwlt_pkg::SEQ_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [47:0]                     s_tdata,   // rx_seqno, rx_tag, rx_full
  input  logic [1:0]                      s_tuser,   // operation
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // seqno, missed_flag, missed_seqno, timeout_us, window_now, sent_total,
  // received_total, missing_total, finished
  output logic [135:0]                    m_tdata,
  output logic [2:0]                      m_tuser,   // kind
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [fwlt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fwlt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fwlt_pkg::*;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  result_t res;

  fwlt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_seqno  (s_tdata[31:0]),
    .in_tag    (s_tdata[39:32]),
    .in_full   (s_tdata[40]),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  fwlt_back #(
    .SEQ_BITS (SEQ_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (m_tvalid),
    .res       (res),
    .res_ready (m_tready)
  );

  assign m_tuser = res.kind;
  assign m_tlast = res.last;
  assign m_tdata = {5'b0, res.finished, res.missing_total, res.received_total,
                    res.sent_total, res.window_now, res.timeout_us,
                    res.missed_seqno, res.missed_flag, res.seqno};

endmodule

// File: tb/tb_flow_window_loss_tracker.sv
// ----------------------------------------------------------------------------
// tb_flow_window_loss_tracker
// Self-checking bench: drives send, receive, timeout and finish events over
// the input stream, predicts every result from a model of the window, the
// sequence table and the counters, and compares the output stream against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_flow_window_loss_tracker;
  import fwlt_pkg::*;

  class loss_scoreboard;
    bit               tbl_live[TABLE_ENTRIES];
    logic [CNT_W-1:0] tbl_seq[TABLE_ENTRIES];
    logic [CNT_W-1:0] sent, recv, tmo, pkt;
    logic [MISS_W-1:0] miss;
    logic [WIN_W-1:0] win, wlim;
    logic [1:0]       burst;
    bit               running, hfit;
    result_t          pending[$];
    int               errors;

    function new();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tbl_live[i] = 0;
        tbl_seq[i] = '0;
      end
      sent = '0; recv = '0; miss = '0; win = '0; burst = 2'd1;
      tmo = TIMEOUT_RESET; running = 1; pkt = 20'd1; wlim = '0; hfit = 1;
      errors = 0;
    endfunction

    function bit over();
      return !running || (int'(recv) + int'(miss) >= int'(pkt));
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_PACKET_COUNT) pkt = val;
      else if (idx == CFG_WINDOW_LIMIT) wlim = val[WIN_W-1:0];
      else if (idx == CFG_HEADER_FITS) hfit = val[0];
    endfunction

    function void add_miss();
      if (miss < MISSING_MAX) miss++;
    endfunction

    function void push_res(kind_t k, logic [CNT_W-1:0] s, bit mf, logic [CNT_W-1:0] ms,
                           bit lst);
      result_t r;
      r.kind = k; r.seqno = s; r.missed_flag = mf; r.missed_seqno = mf ? ms : '0;
      r.timeout_us = tmo; r.window_now = win; r.sent_total = sent;
      r.received_total = recv; r.missing_total = miss; r.finished = over();
      r.last = lst;
      pending.push_back(r);
    endfunction

    function void note(cmd_t c);
      logic [CNT_W-1:0] seqs[2], ms[2], sc;
      logic [MISS_W-1:0] mc;
      logic [IDX_W-1:0] idx;
      bit mf[2], ok, mflag;
      logic [CNT_W-1:0] mseq;
      int n;
      n = 0; ok = 0; mflag = 0; mseq = '0;
      case (c.op)
        OP_SEND: begin
          if (over()) return;
          for (int k = 0; k < burst && k < 2; k++) begin
            if (int'(sent) <= int'(recv) + int'(miss) + int'(win) && sent < pkt &&
                sent < CNT_MAX) begin
              sent++;
              idx = sent[IDX_W-1:0];
              mf[n] = 0; ms[n] = '0;
              if (hfit) begin
                if (tbl_live[idx]) begin
                  mf[n] = 1; ms[n] = tbl_seq[idx]; add_miss();
                end
                tbl_live[idx] = 1; tbl_seq[idx] = sent;
              end
              seqs[n] = sent;
              n++;
            end
          end
          if (n == 2) begin
            sc = sent; mc = miss;
            sent = seqs[0];
            if (mf[1]) miss = mc - 1'b1;
            push_res(KIND_SENT, seqs[0], mf[0], ms[0], 0);
            sent = sc; miss = mc;
            push_res(KIND_SENT, seqs[1], mf[1], ms[1], 1);
          end else if (n == 1) begin
            push_res(KIND_SENT, seqs[0], mf[0], ms[0], 1);
          end
        end
        OP_RECV: begin
          if (over()) begin
            push_res(KIND_DISCARD, '0, 0, '0, 1);
            return;
          end
          if (tbl_live[c.rx_tag]) begin
            if (!c.rx_full) ok = 1;
            else if ({12'd0, tbl_seq[c.rx_tag]} == c.rx_seqno) begin
              ok = 1;
              if (c.rx_seqno == {12'd0, pkt}) running = 0;
            end
          end
          if (!ok) begin
            burst = 2'd0;
            push_res(KIND_DISCARD, '0, 0, '0, 1);
            return;
          end
          tbl_live[c.rx_tag] = 0;
          if (recv < CNT_MAX) recv++;
          if (burst == 2'd2 && tmo > TIMEOUT_FLOOR) tmo = tmo - (tmo >> 4);
          burst = 2'd2;
          if (win < wlim) win++;
          push_res(KIND_ACCEPT, '0, 0, '0, 1);
        end
        OP_TIMEOUT: begin
          if (over()) begin
            push_res(KIND_TIMEOUT, '0, 0, '0, 1);
            return;
          end
          if (burst == 2'd1) win = '0;
          burst = 2'd1;
          if (tmo < TIMEOUT_DOUBLE_BELOW) begin
            tmo = {tmo[CNT_W-2:0], 1'b0};
          end else begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
              idx = sent[IDX_W-1:0] + 8'd1 + k[IDX_W-1:0];
              if (tbl_live[idx]) begin
                mflag = 1; mseq = tbl_seq[idx]; tbl_live[idx] = 0; add_miss();
                break;
              end
            end
            tmo = TIMEOUT_CEIL;
          end
          push_res(KIND_TIMEOUT, '0, mflag, mseq, 1);
        end
        default: begin
          for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (tbl_live[k]) begin
              if (!mflag) begin
                mflag = 1; mseq = tbl_seq[k];
              end
              tbl_live[k] = 0;
              add_miss();
            end
          end
          running = 0;
          push_res(KIND_FINISH, '0, mflag, mseq, 1);
        end
      endcase
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check(result_t r);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer, kind %0d", r.kind);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("kind", 32'(e.kind), 32'(r.kind));
      cmp("seqno", 32'(e.seqno), 32'(r.seqno));
      cmp("missed_flag", 32'(e.missed_flag), 32'(r.missed_flag));
      cmp("missed_seqno", 32'(e.missed_seqno), 32'(r.missed_seqno));
      cmp("timeout_us", 32'(e.timeout_us), 32'(r.timeout_us));
      cmp("window_now", 32'(e.window_now), 32'(r.window_now));
      cmp("sent_total", 32'(e.sent_total), 32'(r.sent_total));
      cmp("received_total", 32'(e.received_total), 32'(r.received_total));
      cmp("missing_total", 32'(e.missing_total), 32'(r.missing_total));
      cmp("finished", 32'(e.finished), 32'(r.finished));
      cmp("last", 32'(e.last), 32'(r.last));
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast, cfg_we;
  logic [47:0] s_tdata;
  logic [1:0] s_tuser;
  logic [135:0] m_tdata;
  logic [2:0] m_tuser;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  loss_scoreboard sb;
  int gap_pct, stall_pct, cycles;
  result_t got;

  flow_window_loss_tracker dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.kind = kind_t'(m_tuser);
      got.seqno = m_tdata[19:0];
      got.missed_flag = m_tdata[20];
      got.missed_seqno = m_tdata[40:21];
      got.timeout_us = m_tdata[60:41];
      got.window_now = m_tdata[68:61];
      got.sent_total = m_tdata[88:69];
      got.received_total = m_tdata[108:89];
      got.missing_total = m_tdata[129:109];
      got.finished = m_tdata[130];
      got.last = m_tlast;
      sb.check(got);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic push(cmd_t c);
    bit rdy;
    if ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c.op;
    s_tdata <= {7'd0, c.rx_full, c.rx_tag, c.rx_seqno};
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    sb.note(c);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic cmd_t mk(op_t op, logic [31:0] seq, logic [7:0] tag, bit full);
    cmd_t c;
    c.op = op; c.rx_seqno = seq; c.rx_tag = tag; c.rx_full = full;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    int r, base;
    logic [7:0] idx;
    cmd_t c;
    c = mk(OP_SEND, $urandom(), 8'($urandom_range(255)), 1'($urandom_range(1)));
    r = $urandom_range(99);
    if (r < 42) return c;
    if (r >= 88) begin
      c.op = OP_TIMEOUT;
      return c;
    end
    c.op = OP_RECV;
    if ($urandom_range(99) < 75) begin
      base = $urandom_range(255);
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        idx = base[7:0] + k[7:0];
        if (sb.tbl_live[idx]) begin
          c.rx_tag = idx;
          if ($urandom_range(99) < 85) begin
            c.rx_full = 1'b1;
            c.rx_seqno = {12'd0, sb.tbl_seq[idx]};
          end else begin
            c.rx_full = 1'b0;
          end
          break;
        end
      end
    end
    return c;
  endfunction

  task automatic random_run(int n);
    repeat (n) push(rand_cmd());
  endtask

  initial begin
    logic [CNT_W-1:0] top;
    sb = new();
    clk = 0; rst = 1; cycles = 0;
    s_tvalid = 0; s_tdata = '0; s_tuser = OP_SEND; m_tready = 0;
    cfg_we = 0; cfg_index = CFG_PACKET_COUNT; cfg_data = '0;
    gap_pct = 22; stall_pct = 76;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CFG_PACKET_COUNT, 20'd1000000);
    write_reg(CFG_WINDOW_LIMIT, 20'd255);
    write_reg(CFG_HEADER_FITS, 20'd1);

    push(mk(OP_SEND, 32'd0, 8'd0, 1'b0));
    push(mk(OP_RECV, 32'd1, 8'd1, 1'b1));
    push(mk(OP_SEND, 32'd0, 8'd0, 1'b0));
    push(mk(OP_RECV, 32'd0, 8'd2, 1'b0));
    push(mk(OP_RECV, 32'hFFFFFFFF, 8'd3, 1'b1));
    push(mk(OP_SEND, 32'd0, 8'd0, 1'b0));
    push(mk(OP_RECV, 32'd0, 8'hFF, 1'b1));
    push(mk(OP_RECV, 32'hFFFFFFFF, 8'hFF, 1'b0));
    push(mk(OP_RECV, 32'd3, 8'd3, 1'b1));
    push(mk(OP_SEND, 32'd0, 8'd0, 1'b0));
    push(mk(OP_TIMEOUT, 32'd0, 8'd0, 1'b0));
    push(mk(OP_TIMEOUT, 32'd0, 8'd0, 1'b0));
    push(mk(OP_TIMEOUT, 32'd0, 8'd0, 1'b0));
    push(mk(OP_TIMEOUT, 32'd0, 8'd0, 1'b0));
    push(mk(OP_TIMEOUT, 32'd0, 8'd0, 1'b0));
    push(mk(OP_TIMEOUT, 32'd0, 8'd0, 1'b0));
    push(mk(OP_SEND, 32'd0, 8'd0, 1'b0));
    push(mk(OP_SEND, 32'd0, 8'd0, 1'b0));
    random_run(230);
    drain();

    gap_pct = 76; stall_pct = 22;
    write_reg(CFG_HEADER_FITS, 20'd0);
    write_reg(CFG_WINDOW_LIMIT, 20'd0);
    random_run(40);
    drain();
    write_reg(CFG_HEADER_FITS, 20'd1);
    write_reg(CFG_WINDOW_LIMIT, 20'd3);
    random_run(200);
    drain();

    gap_pct = 0; stall_pct = 0;
    write_reg(CFG_PACKET_COUNT, 20'd1);
    random_run(20);
    drain();
    write_reg(CFG_PACKET_COUNT, 20'd1000000);
    write_reg(CFG_WINDOW_LIMIT, 20'd128);
    random_run(100);
    drain();
    random_run(100);
    drain();

    top = sb.sent;
    if (sb.tbl_live[top[7:0]] && sb.tbl_seq[top[7:0]] == top &&
        int'(sb.recv) + int'(sb.miss) < int'(top)) begin
      write_reg(CFG_PACKET_COUNT, top);
      push(mk(OP_RECV, {12'd0, top}, top[7:0], 1'b1));
      push(mk(OP_SEND, 32'd0, 8'd0, 1'b0));
      drain();
      write_reg(CFG_PACKET_COUNT, 20'd1000000);
    end
    push(mk(OP_FINISH, 32'd0, 8'd0, 1'b0));
    push(mk(OP_SEND, 32'd0, 8'd0, 1'b0));
    push(mk(OP_RECV, 32'd5, 8'd5, 1'b1));
    push(mk(OP_TIMEOUT, 32'd0, 8'd0, 1'b0));
    push(mk(OP_FINISH, 32'd0, 8'd0, 1'b0));
    drain();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
